// File: hdl/bayer_demosaic_gradient_green_unit_assert.svh
// assertion macros for the bayer demosaic block
`ifndef BAYER_DEMOSAIC_GRADIENT_GREEN_UNIT_ASSERT_SVH
`define BAYER_DEMOSAIC_GRADIENT_GREEN_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BDG_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define BDG_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define BDG_ASSERT(label, cond)
`define BDG_IMPLY(label, pre, post)
`endif
`endif

// File: hdl/bdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdg_pkg
// shared types and constants for the bayer demosaic block
// ----------------------------------------------------------------------------
package bdg_pkg;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam logic [1:0] REG_CFA    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // classified work for the back part
  typedef struct packed {
    logic        green_site;
    logic        red_row;
    logic [7:0]  ctr;
    logic [8:0]  hsum;
    logic [8:0]  vsum;
    logic [9:0]  diag;
    logic [7:0]  gh;
    logic [7:0]  gv;
    logic [10:0] col;
    logic [11:0] row;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] col;
    logic [11:0] row;
    logic        last;
  } res_t;
endpackage

// File: hdl/bdg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdg_pix_if / bdg_rgb_if
// valid/ready channels for input samples and output colours
// ----------------------------------------------------------------------------
interface bdg_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_pixel;
  logic       frame_start;
  modport source (output valid, raw_pixel, frame_start, input ready);
  modport sink (input valid, raw_pixel, frame_start, output ready);
endinterface

interface bdg_rgb_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [10:0] pixel_col;
  logic [11:0] pixel_row;
  logic        frame_last;
  modport source (output valid, red_out, green_out, blue_out, pixel_col, pixel_row,
                  frame_last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, pixel_col, pixel_row,
                frame_last, output ready);
endinterface

// File: hdl/bdg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdg_front
// line stores, 5x5 window and site classification
// ----------------------------------------------------------------------------
module bdg_front #(
  parameter int MAX_WIDTH  = bdg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bdg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          raw_pixel,
  input  logic                frame_start,
  input  logic [1:0]          cfa,
  input  logic [11:0]         width_reg,
  input  logic [12:0]         height_reg,
  input  logic                q_full,
  output logic                job_valid,
  output bdg_pkg::job_t       job
);
  import bdg_pkg::*;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = XW + 1;
  localparam int RW = $clog2(MAX_HEIGHT) + 1;

  // phase 0 takes a sample and issues reads, phase 1 updates the window
  logic         phase;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] wdt;
  logic [RW-1:0] hgt;
  logic [XW-1:0] x;
  logic [RW-1:0] y;
  logic [7:0]   px;
  logic         emit;
  logic [7:0]   mem0 [MAX_WIDTH];
  logic [7:0]   mem1 [MAX_WIDTH];
  logic [7:0]   mem2 [MAX_WIDTH];
  logic [7:0]   mem3 [MAX_WIDTH];
  logic [7:0]   rd [4];
  logic [7:0]   win [5][5];
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] cs;
  logic [RW-1:0] rs;
  logic         take;

  always_comb begin
    if (width_reg < 12'd5) wdt = CW'(5);
    else if ({1'b0, width_reg} > 13'(MAX_WIDTH)) wdt = CW'(MAX_WIDTH);
    else wdt = CW'(width_reg);
    if (height_reg < 13'd5) hgt = RW'(5);
    else if ({1'b0, height_reg} > 14'(MAX_HEIGHT)) hgt = RW'(MAX_HEIGHT);
    else hgt = RW'(height_reg);
  end

  assign in_ready = !phase && !q_full;
  assign take = in_valid && in_ready;
  assign cs = frame_start ? '0 : col_count;
  assign rs = frame_start ? '0 : row_count;

  always_comb begin
    col_next = cs + CW'(1);
    row_next = rs;
    if (col_next >= wdt) begin
      col_next = '0;
      row_next = rs + RW'(1);
      if (row_next >= hgt) row_next = '0;
    end
  end

  logic [XW-1:0] xs;
  assign xs = (cs >= CW'(MAX_WIDTH)) ? XW'(MAX_WIDTH - 1) : cs[XW-1:0];

  always_ff @(posedge clk) begin
    if (take) begin
      rd[2'd0 - rs[1:0]] <= mem0[xs];
      rd[2'd1 - rs[1:0]] <= mem1[xs];
      rd[2'd2 - rs[1:0]] <= mem2[xs];
      rd[2'd3 - rs[1:0]] <= mem3[xs];
      unique case (rs[1:0])
        2'd0: mem0[xs] <= raw_pixel;
        2'd1: mem1[xs] <= raw_pixel;
        2'd2: mem2[xs] <= raw_pixel;
        default: mem3[xs] <= raw_pixel;
      endcase
      x  <= xs;
      y  <= rs;
      px <= raw_pixel;
      emit <= (rs >= RW'(4)) && (cs >= CW'(4)) && (cs < wdt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      col_count <= '0;
      row_count <= '0;
      for (int r = 0; r < 5; r++) for (int c = 0; c < 5; c++) win[r][c] <= '0;
    end else if (take) begin
      phase <= 1'b1;
      col_count <= col_next;
      row_count <= row_next;
    end else if (phase) begin
      phase <= 1'b0;
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) win[r][c] <= win[r][c+1];
        win[r][4] <= (r < 4) ? rd[r] : px;
      end
    end
  end

  // classify from the window as it stands after the shift
  logic [7:0] nw [5][5];
  always_comb begin
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) nw[r][c] = win[r][c+1];
      nw[r][4] = (r < 4) ? rd[r] : px;
    end
  end

  logic odd;
  assign odd = x[0] ^ y[0];
  assign job_valid = phase && emit && (y < hgt);
  always_comb begin
    job.green_site = cfa[1] ? !odd : odd;
    job.red_row = (y[0] == cfa[0]);
    job.ctr  = nw[2][2];
    job.hsum = {1'b0, nw[2][1]} + {1'b0, nw[2][3]};
    job.vsum = {1'b0, nw[1][2]} + {1'b0, nw[3][2]};
    job.diag = 10'(nw[1][1]) + 10'(nw[1][3]) + 10'(nw[3][1]) + 10'(nw[3][3]);
    job.gh = (nw[2][4] > nw[2][0]) ? nw[2][4] - nw[2][0] : nw[2][0] - nw[2][4];
    job.gv = (nw[4][2] > nw[0][2]) ? nw[4][2] - nw[0][2] : nw[0][2] - nw[4][2];
    job.col = 11'(CW'(x) - CW'(2));
    job.row = 12'(y - RW'(2));
    job.last = (CW'(x) == wdt - CW'(1)) && (y == hgt - RW'(1));
  end
endmodule

// File: hdl/bdg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdg_back
// job queue, weighted green by restoring division, output register
// ----------------------------------------------------------------------------
module bdg_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  bdg_pkg::job_t job,
  output logic          q_full,
  output logic          res_valid,
  input  logic          res_ready,
  output bdg_pkg::res_t res
);
  import bdg_pkg::*;
`include "bayer_demosaic_gradient_green_unit_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  job_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic [1:0] st;
  job_t       cur;
  logic [18:0] num;
  logic [10:0] den;
  logic [10:0] rem;
  logic [4:0]  step;
  logic        pop;
  logic [11:0] trial;
  logic [18:0] qfin;

  assign q_full = (cnt == 2'd2);
  assign pop = (st == ST_IDLE) && (cnt != 0) && !res_valid;

  always_ff @(posedge clk) if (job_valid) q[wp] <= job;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (job_valid) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(job_valid) - 2'(pop);
    end
  end

  // numerator bits leave the top of num, quotient bits enter at the bottom
  assign trial = {rem, num[18]} - {1'b0, den};
  assign qfin = {num[17:0], !trial[11]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (st)
        ST_IDLE: if (pop) begin
          cur <= q[rp];
          st <= ST_MUL;
        end
        ST_MUL: begin
          num <= 19'(cur.hsum) * (19'd1 + 19'(cur.gv)) +
                 19'(cur.vsum) * (19'd1 + 19'(cur.gh));
          den <= {10'd2 + 10'(cur.gh) + 10'(cur.gv), 1'b0};
          step <= '0;
          rem <= '0;
          if (cur.green_site) begin
            res.green <= cur.ctr;
            res.red  <= cur.red_row ? cur.hsum[8:1] : cur.vsum[8:1];
            res.blue <= cur.red_row ? cur.vsum[8:1] : cur.hsum[8:1];
            res.col <= cur.col; res.row <= cur.row; res.last <= cur.last;
            res_valid <= 1'b1;
            st <= ST_IDLE;
          end else st <= ST_DIV;
        end
        ST_DIV: begin
          if (!trial[11]) rem <= trial[10:0];
          else rem <= {rem[9:0], num[18]};
          num <= qfin;
          if (step == 5'd18) begin
            res.green <= (qfin[18:8] != '0) ? 8'hff : qfin[7:0];
            res.red  <= cur.red_row ? cur.ctr : cur.diag[9:2];
            res.blue <= cur.red_row ? cur.diag[9:2] : cur.ctr;
            res.col <= cur.col; res.row <= cur.row; res.last <= cur.last;
            res_valid <= 1'b1;
            st <= ST_IDLE;
          end
          step <= step + 5'd1;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  `BDG_ASSERT(a_no_overflow, !(job_valid && q_full))
  `BDG_IMPLY(a_pop_starts, pop, st == ST_MUL)
  `BDG_ASSERT(a_cnt_range, cnt != 2'd3)
endmodule

// File: hdl/bayer_demosaic_gradient_green_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_demosaic_gradient_green_unit
// bayer demosaic, gradient weighted green and bilinear red/blue
// ----------------------------------------------------------------------------
// Each sample is taken with a line store read and then shifts the window in
// the front part, which takes no new sample until that shift is done. The
// back part loads a word from the queue, then forms the sums; green sites
// then have their result, red and blue sites go on to a restoring division.
// A result must be taken before the next word is loaded. A two-entry queue
// between the parts lets the front run ahead until it fills, after which the
// input waits on the back part.
module bayer_demosaic_gradient_green_unit #(
  parameter int MAX_WIDTH  = bdg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bdg_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  bdg_pix_if.sink     pix,
  bdg_rgb_if.source   rgb,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bdg_pkg::*;
  logic [1:0]  cfa;
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic        q_full, job_valid;
  job_t        job;
  res_t        res;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfa <= '0; width_reg <= 12'd640; height_reg <= 13'd480;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_CFA:    cfa <= pwdata[1:0];
        REG_WIDTH:  width_reg <= pwdata[11:0];
        REG_HEIGHT: height_reg <= pwdata[12:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_CFA:    prdata = {30'd0, cfa};
      REG_WIDTH:  prdata = {20'd0, width_reg};
      REG_HEIGHT: prdata = {19'd0, height_reg};
      default:    prdata = '0;
    endcase
  end

  bdg_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .in_valid(pix.valid), .in_ready(pix.ready),
    .raw_pixel(pix.raw_pixel), .frame_start(pix.frame_start),
    .cfa, .width_reg, .height_reg, .q_full, .job_valid, .job);

  bdg_back u_back (.clk, .rst, .job_valid, .job, .q_full,
    .res_valid(rgb.valid), .res_ready(rgb.ready), .res);

  assign rgb.red_out = res.red;
  assign rgb.green_out = res.green;
  assign rgb.blue_out = res.blue;
  assign rgb.pixel_col = res.col;
  assign rgb.pixel_row = res.row;
  assign rgb.frame_last = res.last;
endmodule
